/* sv/clt_pkg.sv */
// Shared types and constants for the cursor list table.
`timescale 1ns / 1ps
package clt_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned REQ_WIDTH      = 4;
  localparam int unsigned STATUS_WIDTH   = 3;

  typedef enum logic [REQ_WIDTH-1:0] {
    REQ_INSERT  = 4'd0,
    REQ_REMOVE  = 4'd1,
    REQ_REPLACE = 4'd2,
    REQ_CLEAR   = 4'd3,
    REQ_FIRST   = 4'd4,
    REQ_LAST    = 4'd5,
    REQ_NEXT    = 4'd6,
    REQ_PRIOR   = 4'd7,
    REQ_READ    = 4'd8,
    REQ_SWAP    = 4'd9,
    REQ_FIND    = 4'd10
  } req_e;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_BAD_POS   = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_FIND,
    ST_READ,
    ST_SWAP_RD,
    ST_SWAP_WA,
    ST_SWAP_WB,
    ST_DONE
  } state_e;

endpackage

/* sv/clt_mem.sv */
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module clt_mem #(
  parameter int unsigned DEPTH = clt_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = clt_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/clt_ctrl.sv */
// Request sequencer: walks the entry store one address per cycle and holds the result beat.
`timescale 1ns / 1ps
module clt_ctrl #(
  parameter int unsigned CAPACITY   = clt_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = clt_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [clt_pkg::REQ_WIDTH-1:0]     req_type_i,
  input  logic [DATA_WIDTH-1:0]             item_value_i,
  input  logic [AW-1:0]                     target_pos_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [CW-1:0]                     cfg_limit_items_i,
  output logic                              mem_we_o,
  output logic [AW-1:0]                     mem_waddr_o,
  output logic [DATA_WIDTH-1:0]             mem_wdata_o,
  output logic                              mem_re_o,
  output logic [AW-1:0]                     mem_raddr_o,
  input  logic [DATA_WIDTH-1:0]             mem_rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [clt_pkg::STATUS_WIDTH-1:0]  status_o,
  output logic [DATA_WIDTH-1:0]             read_value_o,
  output logic                              moved_o,
  output logic [CW-1:0]                     count_now_o,
  output logic [AW-1:0]                     cursor_now_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  clt_pkg::state_e  state_q, state_d;
  clt_pkg::req_e    req_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [AW-1:0]    tgt_q;
  logic [CW-1:0]    limit_q;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;
  logic [DATA_WIDTH-1:0] hold_q, hold_d;
  clt_pkg::status_e status_q, status_d;
  logic [DATA_WIDTH-1:0] rd_q, rd_d;
  logic             moved_q, moved_d;
  logic             out_valid_q, out_valid_d;
  clt_pkg::status_e o_status_q;
  logic [DATA_WIDTH-1:0] o_rd_q;
  logic             o_moved_q;
  logic [CW-1:0]    o_count_q;
  logic [AW-1:0]    o_cur_q;
  logic             o_empty_q;
  logic             o_full_q;

  logic             in_accept;
  logic [CW-1:0]    lim;
  logic             empty;
  logic             full;
  logic [CW-1:0]    cur_ext;
  logic             tgt_bad;
  logic             up_more;
  logic             dn_more;
  logic             fd_more;
  logic             hit;
  logic             out_free;
  logic             load;

  assign in_stall_o  = (state_q != clt_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (limit_q == '0) begin
      lim = CW'(1);
    end else if (limit_q > CW'(CAPACITY)) begin
      lim = CW'(CAPACITY);
    end else begin
      lim = limit_q;
    end
  end

  assign empty    = (count_q == '0);
  assign full     = (count_q >= lim);
  assign cur_ext  = CW'(cur_q);
  assign tgt_bad  = (CW'(tgt_q) >= count_q);
  assign up_more  = (idx_q > CW'(pos_q));
  assign dn_more  = ((idx_q + CW'(1)) < count_q);
  assign fd_more  = (idx_q < count_q);
  assign hit      = pend_q && (mem_rdata_i == val_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = (state_q == clt_pkg::ST_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      clt_pkg::ST_IDLE: begin
        if (in_accept) state_d = clt_pkg::ST_DISPATCH;
      end
      clt_pkg::ST_DISPATCH: begin
        state_d = clt_pkg::ST_DONE;
        case (req_q)
          clt_pkg::REQ_INSERT: begin
            if (!full) state_d = clt_pkg::ST_SHIFT_UP;
          end
          clt_pkg::REQ_REMOVE: begin
            if (!empty) state_d = clt_pkg::ST_SHIFT_DN;
          end
          clt_pkg::REQ_READ: begin
            if (!empty) state_d = clt_pkg::ST_READ;
          end
          clt_pkg::REQ_SWAP: begin
            if (!empty && !tgt_bad) state_d = clt_pkg::ST_SWAP_RD;
          end
          clt_pkg::REQ_FIND: begin
            if (!empty) state_d = clt_pkg::ST_FIND;
          end
          default: state_d = clt_pkg::ST_DONE;
        endcase
      end
      clt_pkg::ST_SHIFT_UP: begin
        if (!up_more && !pend_q) state_d = clt_pkg::ST_DONE;
      end
      clt_pkg::ST_SHIFT_DN: begin
        if (!dn_more && !pend_q) state_d = clt_pkg::ST_DONE;
      end
      clt_pkg::ST_FIND: begin
        if (hit || !fd_more) state_d = clt_pkg::ST_DONE;
      end
      clt_pkg::ST_READ:    state_d = clt_pkg::ST_DONE;
      clt_pkg::ST_SWAP_RD: state_d = clt_pkg::ST_SWAP_WA;
      clt_pkg::ST_SWAP_WA: state_d = clt_pkg::ST_SWAP_WB;
      clt_pkg::ST_SWAP_WB: state_d = clt_pkg::ST_DONE;
      clt_pkg::ST_DONE: begin
        if (out_free) state_d = clt_pkg::ST_IDLE;
      end
      default: state_d = clt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    hold_d      = hold_q;
    status_d    = status_q;
    rd_d        = rd_q;
    moved_d     = moved_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q;
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = cur_q;
    case (state_q)
      clt_pkg::ST_DISPATCH: begin
        status_d = clt_pkg::STAT_OK;
        rd_d     = '0;
        moved_d  = 1'b0;
        pend_d   = 1'b0;
        case (req_q)
          clt_pkg::REQ_INSERT: begin
            if (full) begin
              status_d = clt_pkg::STAT_FULL;
            end else begin
              idx_d = count_q;
              pos_d = empty ? '0 : AW'(cur_q + AW'(1));
            end
          end
          clt_pkg::REQ_REMOVE: begin
            if (empty) status_d = clt_pkg::STAT_EMPTY;
            else idx_d = cur_ext;
          end
          clt_pkg::REQ_REPLACE: begin
            if (empty) begin
              status_d = clt_pkg::STAT_EMPTY;
            end else begin
              mem_we_o = 1'b1;
            end
          end
          clt_pkg::REQ_CLEAR: begin
            count_d = '0;
            cur_d   = '0;
          end
          clt_pkg::REQ_FIRST: begin
            if (empty) status_d = clt_pkg::STAT_EMPTY;
            else cur_d = '0;
          end
          clt_pkg::REQ_LAST: begin
            if (empty) status_d = clt_pkg::STAT_EMPTY;
            else cur_d = AW'(count_q - CW'(1));
          end
          clt_pkg::REQ_NEXT: begin
            if (empty) begin
              status_d = clt_pkg::STAT_EMPTY;
            end else if ((cur_ext + CW'(1)) < count_q) begin
              cur_d   = AW'(cur_q + AW'(1));
              moved_d = 1'b1;
            end
          end
          clt_pkg::REQ_PRIOR: begin
            if (empty) begin
              status_d = clt_pkg::STAT_EMPTY;
            end else if (cur_q != '0) begin
              cur_d   = AW'(cur_q - AW'(1));
              moved_d = 1'b1;
            end
          end
          clt_pkg::REQ_READ: begin
            if (empty) begin
              status_d = clt_pkg::STAT_EMPTY;
            end else begin
              mem_re_o = 1'b1;
            end
          end
          clt_pkg::REQ_SWAP: begin
            if (empty) begin
              status_d = clt_pkg::STAT_EMPTY;
            end else if (tgt_bad) begin
              status_d = clt_pkg::STAT_BAD_POS;
            end else begin
              mem_re_o = 1'b1;
            end
          end
          clt_pkg::REQ_FIND: begin
            if (empty) begin
              status_d = clt_pkg::STAT_EMPTY;
            end else begin
              status_d = clt_pkg::STAT_NOT_FOUND;
              idx_d    = '0;
            end
          end
          default: status_d = clt_pkg::STAT_OK;
        endcase
      end
      clt_pkg::ST_SHIFT_UP: begin
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pend_addr_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (up_more) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(idx_q - CW'(1));
          pend_d      = 1'b1;
          pend_addr_d = AW'(idx_q);
          idx_d       = idx_q - CW'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pos_q;
          mem_wdata_o = val_q;
          count_d     = count_q + CW'(1);
          cur_d       = pos_q;
        end
      end
      clt_pkg::ST_SHIFT_DN: begin
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pend_addr_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (dn_more) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(idx_q + CW'(1));
          pend_d      = 1'b1;
          pend_addr_d = AW'(idx_q);
          idx_d       = idx_q + CW'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          count_d = count_q - CW'(1);
          if (cur_ext >= (count_q - CW'(1))) cur_d = '0;
        end
      end
      clt_pkg::ST_FIND: begin
        if (hit) begin
          status_d = clt_pkg::STAT_OK;
          pend_d   = 1'b0;
        end else if (fd_more) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(idx_q);
          pend_d      = 1'b1;
          idx_d       = idx_q + CW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end
      clt_pkg::ST_READ: begin
        rd_d = mem_rdata_i;
      end
      clt_pkg::ST_SWAP_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = tgt_q;
        hold_d      = mem_rdata_i;
      end
      clt_pkg::ST_SWAP_WA: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cur_q;
        mem_wdata_o = mem_rdata_i;
      end
      clt_pkg::ST_SWAP_WB: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tgt_q;
        mem_wdata_o = hold_q;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clt_pkg::ST_IDLE;
      limit_q     <= CW'(CAPACITY);
      count_q     <= '0;
      cur_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_limit_items_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= clt_pkg::req_e'(req_type_i);
      val_q <= item_value_i;
      tgt_q <= target_pos_i;
    end
    pos_q       <= pos_d;
    pend_addr_q <= pend_addr_d;
    hold_q      <= hold_d;
    status_q    <= status_d;
    rd_q        <= rd_d;
    moved_q     <= moved_d;
    if (load) begin
      o_status_q <= status_q;
      o_rd_q     <= rd_q;
      o_moved_q  <= moved_q;
      o_count_q  <= count_q;
      o_cur_q    <= cur_q;
      o_empty_q  <= empty;
      o_full_q   <= full;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = o_status_q;
  assign read_value_o = o_rd_q;
  assign moved_o      = o_moved_q;
  assign count_now_o  = o_count_q;
  assign cursor_now_o = o_cur_q;
  assign is_empty_o   = o_empty_q;
  assign is_full_o    = o_full_q;

endmodule

/* sv/cursor_list_table_top.sv */
// Top level of the cursor list table: sequencer and entry store.
//
//   port group  direction  handshake              beat contents
//   in          to block   in_valid_i/in_stall_o  req_type, item_value, target_pos
//   out         from block out_valid_o/out_stall_i status, read_value, moved, counts, flags
//   cfg         to block   cfg_valid_i/cfg_ready_o limit_items
//
// A request passes dispatch, its work states and the done state, where the result register
// loads. Moves, clear, replace, refused and unknown requests have no work states; read reads
// the cursor entry; swap reads the target, then writes both places; insert shifts count -
// insert position entries, remove count - 1 - cursor; find reads until a hit or the end.
// Walks are set by the single read and write port of the entry store, one address per
// cycle. Reset clears count, cursor and limit (to CAPACITY); entries are not cleared.
// A new beat is taken while a result waits; a result that cannot load behind a stalled
// one holds the sequencer.
`timescale 1ns / 1ps
module cursor_list_table_top #(
  parameter int unsigned CAPACITY   = clt_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = clt_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [clt_pkg::REQ_WIDTH-1:0]    req_type_i,
  input  logic [DATA_WIDTH-1:0]            item_value_i,
  input  logic [AW-1:0]                    target_pos_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [CW-1:0]                    cfg_limit_items_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [clt_pkg::STATUS_WIDTH-1:0] status_o,
  output logic [DATA_WIDTH-1:0]            read_value_o,
  output logic                             moved_o,
  output logic [CW-1:0]                    count_now_o,
  output logic [AW-1:0]                    cursor_now_o,
  output logic                             is_empty_o,
  output logic                             is_full_o
);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  clt_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .item_value_i      (item_value_i),
    .target_pos_i      (target_pos_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_limit_items_i (cfg_limit_items_i),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_re_o          (mem_re),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .read_value_o      (read_value_o),
    .moved_o           (moved_o),
    .count_now_o       (count_now_o),
    .cursor_now_o      (cursor_now_o),
    .is_empty_o        (is_empty_o),
    .is_full_o         (is_full_o)
  );

  clt_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* sim/cursor_list_table_top_test.sv */
// Self-checking testbench for the cursor list table: directed table, then random request phases.
`timescale 1ns / 1ps
module cursor_list_table_top_test;

  localparam int unsigned CAP = clt_pkg::CAPACITY_DEF;
  localparam int unsigned DW = clt_pkg::DATA_WIDTH_DEF;
  localparam int unsigned RW = clt_pkg::REQ_WIDTH;
  localparam int unsigned SW = clt_pkg::STATUS_WIDTH;
  localparam int unsigned AW = $clog2(CAP);
  localparam int unsigned CW = $clog2(CAP + 1);
  localparam int unsigned ITEMS = 500;
  localparam int unsigned MAX_WAIT = 4;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [RW-1:0] REQ_SPARE_LO = 4'd11;
  localparam logic [RW-1:0] REQ_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [RW-1:0] req;
    logic [DW-1:0] value;
    logic [AW-1:0] pos;
  } list_req_t;

  typedef struct packed {
    clt_pkg::status_e status;
    logic [DW-1:0]    read_value;
    logic             moved;
    logic [CW-1:0]    count_now;
    logic [AW-1:0]    cursor_now;
    logic             is_empty;
    logic             is_full;
  } list_result_t;

  typedef enum {ROW_REQUEST, ROW_LIMIT} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    list_req_t    rq;
    bit           typed;
    list_result_t want;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [RW-1:0]          req_type_i;
  logic [DW-1:0]          item_value_i;
  logic [AW-1:0]          target_pos_i;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CW-1:0]          cfg_limit_items_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [SW-1:0]          status_o;
  logic [DW-1:0]          read_value_o;
  logic                   moved_o;
  logic [CW-1:0]          count_now_o;
  logic [AW-1:0]          cursor_now_o;
  logic                   is_empty_o;
  logic                   is_full_o;

  logic [DW-1:0]  list_mem [CAP];
  int unsigned    list_count;
  int unsigned    list_cursor;
  logic [CW-1:0]  limit_reg;

  list_result_t   expected_q [$];
  plan_row_t      directed_plan [$];
  bit             quiet_phase;
  int unsigned    stall_left;
  int unsigned    hold_cycles;
  int unsigned    fault_count;
  int unsigned    checked_count;
  int unsigned    sent_count;
  int unsigned    limit_writes;
  int unsigned    status_hits [8];

  cursor_list_table_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .item_value_i      (item_value_i),
    .target_pos_i      (target_pos_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_limit_items_i (cfg_limit_items_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .read_value_o      (read_value_o),
    .moved_o           (moved_o),
    .count_now_o       (count_now_o),
    .cursor_now_o      (cursor_now_o),
    .is_empty_o        (is_empty_o),
    .is_full_o         (is_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic list_result_t apply_request(list_req_t rq);
    list_result_t  rs;
    int unsigned   lim;
    int unsigned   pos;
    int unsigned   i;
    logic [DW-1:0] hold;
    bit            was_empty;
    rs = '0;
    rs.status = clt_pkg::STAT_OK;
    lim = (limit_reg == 0) ? 1 : (limit_reg > CAP) ? CAP : limit_reg;
    was_empty = (list_count == 0);
    if (was_empty || list_cursor >= list_count) list_cursor = 0;
    case (rq.req)
      clt_pkg::REQ_INSERT: begin
        if (list_count >= lim) begin
          rs.status = clt_pkg::STAT_FULL;
        end else begin
          pos = was_empty ? 0 : list_cursor + 1;
          for (i = list_count; i > pos; i--) list_mem[AW'(i)] = list_mem[AW'(i - 1)];
          list_mem[AW'(pos)] = rq.value;
          list_count++;
          list_cursor = pos;
        end
      end
      clt_pkg::REQ_REMOVE: begin
        if (was_empty) begin
          rs.status = clt_pkg::STAT_EMPTY;
        end else begin
          for (i = list_cursor; i + 1 < list_count; i++) list_mem[AW'(i)] = list_mem[AW'(i + 1)];
          list_count--;
          if (list_count == 0 || list_cursor >= list_count) list_cursor = 0;
        end
      end
      clt_pkg::REQ_REPLACE: begin
        if (was_empty) rs.status = clt_pkg::STAT_EMPTY;
        else list_mem[AW'(list_cursor)] = rq.value;
      end
      clt_pkg::REQ_CLEAR: begin
        list_count = 0;
        list_cursor = 0;
      end
      clt_pkg::REQ_FIRST: begin
        if (was_empty) rs.status = clt_pkg::STAT_EMPTY;
        else list_cursor = 0;
      end
      clt_pkg::REQ_LAST: begin
        if (was_empty) rs.status = clt_pkg::STAT_EMPTY;
        else list_cursor = list_count - 1;
      end
      clt_pkg::REQ_NEXT: begin
        if (was_empty) begin
          rs.status = clt_pkg::STAT_EMPTY;
        end else if (list_cursor + 1 < list_count) begin
          list_cursor++;
          rs.moved = 1'b1;
        end
      end
      clt_pkg::REQ_PRIOR: begin
        if (was_empty) begin
          rs.status = clt_pkg::STAT_EMPTY;
        end else if (list_cursor != 0) begin
          list_cursor--;
          rs.moved = 1'b1;
        end
      end
      clt_pkg::REQ_READ: begin
        if (was_empty) rs.status = clt_pkg::STAT_EMPTY;
        else rs.read_value = list_mem[AW'(list_cursor)];
      end
      clt_pkg::REQ_SWAP: begin
        if (was_empty) begin
          rs.status = clt_pkg::STAT_EMPTY;
        end else if (rq.pos >= list_count) begin
          rs.status = clt_pkg::STAT_BAD_POS;
        end else begin
          hold = list_mem[AW'(list_cursor)];
          list_mem[AW'(list_cursor)] = list_mem[rq.pos];
          list_mem[rq.pos] = hold;
        end
      end
      clt_pkg::REQ_FIND: begin
        if (was_empty) begin
          rs.status = clt_pkg::STAT_EMPTY;
        end else begin
          rs.status = clt_pkg::STAT_NOT_FOUND;
          for (i = 0; i < list_count; i++) begin
            if (list_mem[AW'(i)] == rq.value) rs.status = clt_pkg::STAT_OK;
          end
        end
      end
      default: ;
    endcase
    rs.count_now = CW'(list_count);
    rs.cursor_now = AW'(list_cursor);
    rs.is_empty = (list_count == 0);
    rs.is_full = (list_count >= lim);
    return rs;
  endfunction

  function automatic list_req_t pick_request();
    list_req_t   rq;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) rq.req = clt_pkg::REQ_INSERT;
    else if (roll < 42) rq.req = clt_pkg::REQ_REMOVE;
    else if (roll < 48) rq.req = clt_pkg::REQ_REPLACE;
    else if (roll < 50) rq.req = clt_pkg::REQ_CLEAR;
    else if (roll < 54) rq.req = clt_pkg::REQ_FIRST;
    else if (roll < 58) rq.req = clt_pkg::REQ_LAST;
    else if (roll < 65) rq.req = clt_pkg::REQ_NEXT;
    else if (roll < 72) rq.req = clt_pkg::REQ_PRIOR;
    else if (roll < 80) rq.req = clt_pkg::REQ_READ;
    else if (roll < 88) rq.req = clt_pkg::REQ_SWAP;
    else if (roll < 96) rq.req = clt_pkg::REQ_FIND;
    else rq.req = RW'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    roll = $urandom_range(0, 9);
    if (roll == 0) rq.value = '0;
    else if (roll == 1) rq.value = '1;
    else if (roll < 5) rq.value = DW'($urandom_range(0, 7));
    else if (roll < 7 && list_count != 0)
      rq.value = list_mem[AW'($urandom_range(0, list_count - 1))];
    else rq.value = DW'($urandom);
    if (list_count != 0 && $urandom_range(0, 4) != 0)
      rq.pos = AW'($urandom_range(0, list_count - 1));
    else rq.pos = AW'($urandom_range(0, CAP - 1));
    return rq;
  endfunction

  function automatic plan_row_t op_row(logic [RW-1:0] req, logic [DW-1:0] val,
                                       logic [AW-1:0] pos);
    plan_row_t row;
    row.kind = ROW_REQUEST;
    row.rq = '{req: req, value: val, pos: pos};
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t typed_row(logic [RW-1:0] req, logic [DW-1:0] val,
                                          logic [AW-1:0] pos, clt_pkg::status_e st,
                                          logic [DW-1:0] rd, logic mv, logic [CW-1:0] cnt,
                                          logic [AW-1:0] cur, logic emp, logic fl);
    plan_row_t row;
    row = op_row(req, val, pos);
    row.typed = 1'b1;
    row.want = '{status: st, read_value: rd, moved: mv, count_now: cnt, cursor_now: cur,
                 is_empty: emp, is_full: fl};
    return row;
  endfunction

  function automatic plan_row_t limit_row(logic [CW-1:0] lim);
    plan_row_t row;
    row = op_row(clt_pkg::REQ_INSERT, '0, '0);
    row.kind = ROW_LIMIT;
    row.rq.value = DW'(lim);
    return row;
  endfunction

  task automatic send_request(list_req_t rq, bit use_typed, list_result_t typed_want);
    int unsigned gap;
    list_result_t pred;
    gap = quiet_phase ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rq.req;
    item_value_i <= rq.value;
    target_pos_i <= rq.pos;
    do @(posedge clk_i); while (in_stall_o);
    pred = apply_request(rq);
    expected_q.push_back(use_typed ? typed_want : pred);
    sent_count++;
  endtask

  task automatic write_limit(logic [CW-1:0] lim);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_limit_items_i <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_reg = lim;
    limit_writes++;
  endtask

  // check each result beat against the oldest expectation, then draw the next stall
  always @(posedge clk_i) begin : result_sink
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      stall_left <= 0;
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.status = clt_pkg::status_e'(status_o);
        got.read_value = read_value_o;
        got.moved = moved_o;
        got.count_now = count_now_o;
        got.cursor_now = cursor_now_o;
        got.is_empty = is_empty_o;
        got.is_full = is_full_o;
        status_hits[status_o]++;
        if (expected_q.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("beat %0d arrived with no request waiting", checked_count);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
              $display("beat %0d mismatch: want st=%0d rd=%h mv=%b cnt=%0d cur=%0d e=%b f=%b",
                       checked_count, want.status, want.read_value, want.moved,
                       want.count_now, want.cursor_now, want.is_empty, want.is_full);
              $display("               got  st=%0d rd=%h mv=%b cnt=%0d cur=%0d e=%b f=%b",
                       got.status, got.read_value, got.moved, got.count_now,
                       got.cursor_now, got.is_empty, got.is_full);
            end
          end
        end
        checked_count++;
        hold_cycles = quiet_phase ? 0 : $urandom_range(0, MAX_WAIT);
        stall_left <= hold_cycles;
        out_stall_i <= (hold_cycles != 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("cursor_list_table_top test failed");
    $finish;
  end

  initial begin : stimulus
    list_req_t     rq;
    logic [CW-1:0] lim;
    int unsigned   sel;
    int unsigned   phase;
    int unsigned   phase_len;
    int unsigned   directed_items;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    req_type_i <= '0;
    item_value_i <= '0;
    target_pos_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_limit_items_i <= '0;
    quiet_phase = 1'b0;
    fault_count = 0;
    checked_count = 0;
    sent_count = 0;
    limit_writes = 0;
    foreach (status_hits[k]) status_hits[k] = 0;
    foreach (list_mem[k]) list_mem[k] = '0;
    list_count = 0;
    list_cursor = 0;
    limit_reg = CW'(CAP);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_plan.push_back(typed_row(clt_pkg::REQ_READ, '0, '0, clt_pkg::STAT_EMPTY,
                                      '0, 0, 0, 0, 1, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_REMOVE, '0, '0, clt_pkg::STAT_EMPTY,
                                      '0, 0, 0, 0, 1, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_REPLACE, '1, '0, clt_pkg::STAT_EMPTY,
                                      '0, 0, 0, 0, 1, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_FIRST, '0, '0, clt_pkg::STAT_EMPTY,
                                      '0, 0, 0, 0, 1, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_LAST, '0, '0, clt_pkg::STAT_EMPTY,
                                      '0, 0, 0, 0, 1, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_NEXT, '0, '0, clt_pkg::STAT_EMPTY,
                                      '0, 0, 0, 0, 1, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_PRIOR, '0, '0, clt_pkg::STAT_EMPTY,
                                      '0, 0, 0, 0, 1, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_SWAP, '0, '0, clt_pkg::STAT_EMPTY,
                                      '0, 0, 0, 0, 1, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_FIND, '1, '0, clt_pkg::STAT_EMPTY,
                                      '0, 0, 0, 0, 1, 0));
    directed_plan.push_back(typed_row(REQ_SPARE_HI, '1, '1, clt_pkg::STAT_OK,
                                      '0, 0, 0, 0, 1, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_INSERT, '1, '0, clt_pkg::STAT_OK,
                                      '0, 0, 1, 0, 0, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_INSERT, '0, '1, clt_pkg::STAT_OK,
                                      '0, 0, 2, 1, 0, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_NEXT, '0, '0, clt_pkg::STAT_OK,
                                      '0, 0, 2, 1, 0, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_PRIOR, '0, '0, clt_pkg::STAT_OK,
                                      '0, 1, 2, 0, 0, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_PRIOR, '0, '0, clt_pkg::STAT_OK,
                                      '0, 0, 2, 0, 0, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_READ, '0, '0, clt_pkg::STAT_OK,
                                      '1, 0, 2, 0, 0, 0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_SWAP, '0, '1, clt_pkg::STAT_BAD_POS,
                                      '0, 0, 2, 0, 0, 0));
    directed_plan.push_back(op_row(clt_pkg::REQ_SWAP, '0, 6'd1));
    directed_plan.push_back(op_row(clt_pkg::REQ_READ, '0, '0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_FIND, 32'h1234_5678, '0,
                                      clt_pkg::STAT_NOT_FOUND, '0, 0, 2, 0, 0, 0));
    directed_plan.push_back(op_row(clt_pkg::REQ_FIND, '1, '0));
    directed_plan.push_back(op_row(clt_pkg::REQ_LAST, '0, '0));
    directed_plan.push_back(op_row(clt_pkg::REQ_REMOVE, '0, '0));
    directed_plan.push_back(op_row(clt_pkg::REQ_REPLACE, 32'hA5A5_A5A5, '0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_CLEAR, '0, '0, clt_pkg::STAT_OK,
                                      '0, 0, 0, 0, 1, 0));
    directed_plan.push_back(limit_row('0));
    directed_plan.push_back(typed_row(clt_pkg::REQ_INSERT, 32'h5A5A_5A5A, '0, clt_pkg::STAT_OK,
                                      '0, 0, 1, 0, 0, 1));
    directed_plan.push_back(typed_row(clt_pkg::REQ_INSERT, 32'h1, '0, clt_pkg::STAT_FULL,
                                      '0, 0, 1, 0, 0, 1));
    directed_plan.push_back(limit_row('1));
    directed_plan.push_back(op_row(clt_pkg::REQ_INSERT, 32'h8000_0001, '0));
    directed_plan.push_back(op_row(clt_pkg::REQ_FIRST, '0, '0));

    directed_items = 0;
    foreach (directed_plan[k]) begin
      if (directed_plan[k].kind == ROW_LIMIT) begin
        write_limit(directed_plan[k].rq.value[CW-1:0]);
      end else begin
        send_request(directed_plan[k].rq, directed_plan[k].typed, directed_plan[k].want);
        directed_items++;
      end
    end

    phase = 0;
    while (sent_count < ITEMS) begin
      sel = (phase < 5) ? phase : $urandom_range(0, 6);
      case (sel)
        0: lim = CW'(CAP);
        1: lim = CW'(1);
        2: lim = '1;
        3: lim = '0;
        4: lim = (list_count > 1) ? CW'(list_count - 1) : CW'(1);
        5: lim = CW'($urandom_range(1, CAP));
        default: lim = CW'($urandom_range(CAP + 1, (1 << CW) - 1));
      endcase
      write_limit(lim);
      quiet_phase = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 80);
      repeat (phase_len) begin
        if (sent_count < ITEMS) begin
          rq = pick_request();
          send_request(rq, 1'b0, '0);
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (%0d directed) over %0d random phases, %0d limit writes",
             sent_count, directed_items, phase, limit_writes);
    $display("results %0d: ok %0d, empty %0d, full %0d, bad position %0d, not found %0d",
             checked_count, status_hits[clt_pkg::STAT_OK], status_hits[clt_pkg::STAT_EMPTY],
             status_hits[clt_pkg::STAT_FULL], status_hits[clt_pkg::STAT_BAD_POS],
             status_hits[clt_pkg::STAT_NOT_FOUND]);
    if (fault_count == 0) begin
      $display("cursor_list_table_top test passed");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("cursor_list_table_top test failed");
    end
    $finish;
  end

endmodule

/* cursor_list_table_top.f */
sv/clt_pkg.sv
sv/clt_mem.sv
sv/clt_ctrl.sv
sv/cursor_list_table_top.sv
sim/cursor_list_table_top_test.sv
